@@ rtl/ffha_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Internal address/length width: HEAP_BYTES up to 65536 needs 17 bits.
    localparam int AW = 17;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [AW-1:0] off;
        logic [AW-1:0] len;
        logic          free;
    } seg_t;

endpackage
`default_nettype wire

@@ rtl/ffha_seg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_seg_ram
// Segment table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_seg_ram
    import ffha_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
)
(
    input  wire  logic          clk,
    input  wire  logic          we,
    input  wire  logic [IW-1:0] waddr,
    input  wire  seg_t          wdata,
    input  wire  logic [IW-1:0] raddr,
    output seg_t                rdata
);

    seg_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// A request word (allocate, free or reallocate) is taken when in_ready is
// high; in_ready stays low until the single result word has been taken.
// Every step goes through the segment table memory and its single registered
// read port. A request scans table entries for the address lookup and the
// first-fit search, and moves entries when a merge closes a gap or a split
// opens one; a reallocate may merge, compact and then split. No clearing
// pass is needed after reset.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_SEGMENTS = 64
)
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        in_valid,
    output logic              in_ready,
    input  wire  logic [1:0]  mode,
    input  wire  logic [15:0] request_size,
    input  wire  logic [15:0] payload_address,
    output logic              out_valid,
    input  wire  logic        out_ready,
    output logic [1:0]        status,
    output logic [15:0]       result_address,
    output logic [15:0]       copy_length
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] RST_LEN = AW'(HEAP_BYTES - HEADER_BYTES);

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_L_RD   = 5'd1;
    localparam logic [4:0] S_L_CK   = 5'd2;
    localparam logic [4:0] S_M_LO   = 5'd3;
    localparam logic [4:0] S_M_LOCK = 5'd4;
    localparam logic [4:0] S_M_HI   = 5'd5;
    localparam logic [4:0] S_M_HICK = 5'd6;
    localparam logic [4:0] S_M_LEN  = 5'd7;
    localparam logic [4:0] S_M_LEN2 = 5'd8;
    localparam logic [4:0] S_M_LEN3 = 5'd9;
    localparam logic [4:0] S_C_RD   = 5'd10;
    localparam logic [4:0] S_C_WR   = 5'd11;
    localparam logic [4:0] S_G_RD   = 5'd12;
    localparam logic [4:0] S_G_CK   = 5'd13;
    localparam logic [4:0] S_O_RD   = 5'd14;
    localparam logic [4:0] S_O_WR   = 5'd15;
    localparam logic [4:0] S_G_SPL  = 5'd16;
    localparam logic [4:0] S_G_SPL2 = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next;
    logic [1:0]    mode_reg, mode_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   addr_reg, addr_next;
    logic [AW-1:0] cur_off_reg, cur_off_next;
    logic [AW-1:0] cur_len_reg, cur_len_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] old_len_reg, old_len_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] result_reg, result_next;
    logic [AW-1:0] copy_reg, copy_next;
    // Entry 0 reads as its reset value until first written.
    logic          init_reg, init_next;
    logic          rd0_reg;

    logic          we;
    logic [CW-1:0] waddr;
    seg_t          wdata;
    logic [CW-1:0] raddr;
    seg_t          ram_rdata;
    seg_t          rdata;
    seg_t          rst_seg;
    logic [CW-1:0] gap;
    logic [AW-1:0] size_ext;

    assign rst_seg  = '{off: HDR, len: RST_LEN, free: 1'b1};
    assign rdata    = rd0_reg ? rst_seg : ram_rdata;
    assign gap      = hi_reg - lo_reg;
    assign size_ext = AW'(size_reg);

    ffha_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .IW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr[IW-1:0]),
        .wdata (wdata),
        .raddr (raddr[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        mode_next    = mode_reg;
        size_next    = size_reg;
        addr_next    = addr_reg;
        cur_off_next = cur_off_reg;
        cur_len_next = cur_len_reg;
        end_next     = end_reg;
        old_len_next = old_len_reg;
        status_next  = status_reg;
        result_next  = result_reg;
        copy_next    = copy_reg;
        init_next    = init_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = rdata;
        raddr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode;
                    size_next   = request_size;
                    addr_next   = payload_address;
                    idx_next    = '0;
                    status_next = ST_NOTFOUND;
                    result_next = '0;
                    copy_next   = '0;
                    priority if (mode == MODE_ALLOC)
                    begin
                        state_next = S_G_RD;
                    end
                    else if (mode == MODE_FREE || mode == MODE_REALLOC)
                    begin
                        state_next = S_L_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            // Find the segment with the given payload address.
            S_L_RD:
            begin
                raddr      = idx_reg;
                state_next = S_L_CK;
            end
            S_L_CK:
            begin
                if (rdata.off == AW'(addr_reg))
                begin
                    if (rdata.free)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        old_len_next = rdata.len;
                        we           = 1'b1;
                        waddr        = idx_reg;
                        wdata.free   = 1'b1;
                        lo_next      = idx_reg;
                        hi_next      = idx_reg;
                        state_next   = S_M_LO;
                    end
                end
                else if (idx_reg + 1'b1 >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_L_RD;
                end
            end
            // Grow the freed run downward, then upward.
            S_M_LO:
            begin
                if (lo_reg == '0)
                begin
                    state_next = S_M_HI;
                end
                else
                begin
                    raddr      = lo_reg - 1'b1;
                    state_next = S_M_LOCK;
                end
            end
            S_M_LOCK:
            begin
                if (rdata.free)
                begin
                    lo_next    = lo_reg - 1'b1;
                    state_next = S_M_LO;
                end
                else
                begin
                    state_next = S_M_HI;
                end
            end
            S_M_HI:
            begin
                if (hi_reg + 1'b1 < count_reg)
                begin
                    raddr      = hi_reg + 1'b1;
                    state_next = S_M_HICK;
                end
                else
                begin
                    state_next = S_M_LEN;
                end
            end
            S_M_HICK:
            begin
                if (rdata.free)
                begin
                    hi_next    = hi_reg + 1'b1;
                    state_next = S_M_HI;
                end
                else
                begin
                    state_next = S_M_LEN;
                end
            end
            S_M_LEN:
            begin
                raddr      = hi_reg;
                state_next = S_M_LEN2;
            end
            S_M_LEN2:
            begin
                end_next   = rdata.off + rdata.len;
                raddr      = lo_reg;
                state_next = S_M_LEN3;
            end
            S_M_LEN3:
            begin
                we         = 1'b1;
                waddr      = lo_reg;
                wdata.len  = end_reg - rdata.off;
                wdata.free = 1'b1;
                if (gap == '0)
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_G_RD;
                    end
                end
                else
                begin
                    k_next     = lo_reg + 1'b1;
                    state_next = S_C_RD;
                end
            end
            // Close the gap left by the merged entries.
            S_C_RD:
            begin
                if (k_reg + gap < count_reg)
                begin
                    raddr      = k_reg + gap;
                    state_next = S_C_WR;
                end
                else
                begin
                    count_next = count_reg - gap;
                    if (mode_reg == MODE_FREE)
                    begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_G_RD;
                    end
                end
            end
            S_C_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg;
                k_next     = k_reg + 1'b1;
                state_next = S_C_RD;
            end
            // First-fit search.
            S_G_RD:
            begin
                raddr      = idx_reg;
                state_next = S_G_CK;
            end
            S_G_CK:
            begin
                if (rdata.free && rdata.len >= size_ext)
                begin
                    cur_off_next = rdata.off;
                    cur_len_next = rdata.len;
                    if (rdata.len > size_ext + HDR)
                    begin
                        if (count_reg >= MAX_CNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            k_next     = count_reg;
                            state_next = S_O_RD;
                        end
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = idx_reg;
                        wdata.free  = 1'b0;
                        result_next = rdata.off;
                        status_next = ST_OK;
                        if (mode_reg == MODE_REALLOC)
                        begin
                            copy_next = old_len_reg;
                        end
                        state_next  = S_DONE;
                    end
                end
                else if (idx_reg + 1'b1 >= count_reg)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_G_RD;
                end
            end
            // Open a slot after the chosen entry.
            S_O_RD:
            begin
                if (k_reg > idx_reg + 1'b1)
                begin
                    raddr      = k_reg - 1'b1;
                    state_next = S_O_WR;
                end
                else
                begin
                    state_next = S_G_SPL;
                end
            end
            S_O_WR:
            begin
                we         = 1'b1;
                waddr      = k_reg;
                k_next     = k_reg - 1'b1;
                state_next = S_O_RD;
            end
            S_G_SPL:
            begin
                we         = 1'b1;
                waddr      = idx_reg + 1'b1;
                wdata      = '{off: cur_off_reg + size_ext + HDR,
                               len: cur_len_reg - size_ext - HDR,
                               free: 1'b1};
                state_next = S_G_SPL2;
            end
            S_G_SPL2:
            begin
                we          = 1'b1;
                waddr       = idx_reg;
                wdata       = '{off: cur_off_reg, len: size_ext, free: 1'b0};
                count_next  = count_reg + 1'b1;
                result_next = cur_off_reg;
                status_next = ST_OK;
                if (mode_reg == MODE_REALLOC)
                begin
                    copy_next = old_len_reg;
                end
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (we && waddr == '0)
        begin
            init_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CW'(1);
            init_reg    <= 1'b1;
            rd0_reg     <= 1'b0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            k_reg       <= '0;
            mode_reg    <= '0;
            size_reg    <= '0;
            addr_reg    <= '0;
            cur_off_reg <= '0;
            cur_len_reg <= '0;
            end_reg     <= '0;
            old_len_reg <= '0;
            status_reg  <= '0;
            result_reg  <= '0;
            copy_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            init_reg    <= init_next;
            rd0_reg     <= init_reg && (raddr == '0);
            idx_reg     <= idx_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            k_reg       <= k_next;
            mode_reg    <= mode_next;
            size_reg    <= size_next;
            addr_reg    <= addr_next;
            cur_off_reg <= cur_off_next;
            cur_len_reg <= cur_len_next;
            end_reg     <= end_next;
            old_len_reg <= old_len_next;
            status_reg  <= status_next;
            result_reg  <= result_next;
            copy_reg    <= copy_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_DONE);
    assign status         = status_reg;
    assign result_address = result_reg[15:0];
    assign copy_length    = copy_reg[15:0];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= MAX_CNT)
        else $error("segment count out of range");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open together");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_address == '0 && copy_length == '0)
        else $error("failed request carries nonzero fields");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |=> $stable(count_reg))
        else $error("table count changed while idle");

endmodule
`default_nettype wire

@@ bench/first_fit_heap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_tb
// Self-checking bench for the first-fit heap allocator. A behavioral copy of
// the segment table predicts every result word; directed rows cover reset,
// extremes, errors and table-full, then random allocate/free/reallocate
// traffic with handshake bursts and back-pressure checks the rest.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top_tb;
    import ffha_pkg::*;

    localparam int HEAP    = 65536;
    localparam int HDR     = 32;
    localparam int MAXSEG  = 64;
    localparam int N_RAND  = 1364;
    localparam int DOG_MAX = 20000;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] addr;
        logic [15:0] copy;
    } alloc_result_t;

    typedef struct {
        logic [1:0]  md;
        logic [15:0] sz;
        logic [15:0] pa;
        bit          typed;   // row carries a typed expectation
        logic [1:0]  st;
        logic [15:0] addr;
        logic [15:0] copy;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [15:0] request_size;
    logic [15:0] payload_address;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] result_address;
    logic [15:0] copy_length;

    // Predictor copy of the segment table, kept in 32-bit arithmetic.
    int unsigned seg_off [MAXSEG];
    int unsigned seg_len [MAXSEG];
    bit          seg_free[MAXSEG];
    int unsigned seg_cnt;

    alloc_result_t pending_results[$];
    logic [15:0]   live_addrs[$];     // payloads believed in use
    int            mismatches;
    int            dog;
    bit            hold_out;          // long receiver hold-off
    bit            no_idle;           // last part of the run
    bit            stim_done;

    first_fit_heap_allocator_top #(
        .HEAP_BYTES  (HEAP),
        .HEADER_BYTES(HDR),
        .MAX_SEGMENTS(MAXSEG)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .request_size   (request_size),
        .payload_address(payload_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_address (result_address),
        .copy_length    (copy_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void table_reset();
        for (int k = 0; k < MAXSEG; k++)
        begin
            seg_off[k]  = 0;
            seg_len[k]  = 0;
            seg_free[k] = 1'b0;
        end
        seg_off[0]  = HDR;
        seg_len[0]  = HEAP - HDR;
        seg_free[0] = 1'b1;
        seg_cnt     = 1;
    endfunction

    // Merge the freed entry with every free neighbor and close the gap.
    function automatic void release_merge(int unsigned idx);
        int unsigned lo;
        int unsigned hi;
        int unsigned gap;
        lo = idx;
        hi = idx;
        seg_free[idx] = 1'b1;
        while (lo > 0 && seg_free[lo-1]) lo--;
        while (hi + 1 < seg_cnt && seg_free[hi+1]) hi++;
        seg_len[lo] = seg_off[hi] + seg_len[hi] - seg_off[lo];
        gap = hi - lo;
        if (gap != 0)
        begin
            for (int unsigned k = lo + 1; k + gap < seg_cnt; k++)
            begin
                seg_off[k]  = seg_off[k+gap];
                seg_len[k]  = seg_len[k+gap];
                seg_free[k] = seg_free[k+gap];
            end
            for (int unsigned k = seg_cnt - gap; k < seg_cnt; k++)
            begin
                seg_off[k]  = 0;
                seg_len[k]  = 0;
                seg_free[k] = 1'b0;
            end
            seg_cnt -= gap;
        end
    endfunction

    // First fit; split when more than size plus a header is left over.
    function automatic logic [1:0] first_fit(int unsigned sz, output int unsigned addr);
        int unsigned i;
        addr = 0;
        for (i = 0; i < seg_cnt; i++)
            if (seg_free[i] && seg_len[i] >= sz) break;
        if (i >= seg_cnt) return ST_NOFIT;
        if (seg_len[i] > sz + HDR)
        begin
            if (seg_cnt >= MAXSEG) return ST_FULL;
            for (int unsigned k = seg_cnt; k > i + 1; k--)
            begin
                seg_off[k]  = seg_off[k-1];
                seg_len[k]  = seg_len[k-1];
                seg_free[k] = seg_free[k-1];
            end
            seg_off[i+1]  = seg_off[i] + sz + HDR;
            seg_len[i+1]  = seg_len[i] - sz - HDR;
            seg_free[i+1] = 1'b1;
            seg_len[i]    = sz;
            seg_cnt++;
        end
        seg_free[i] = 1'b0;
        addr = seg_off[i];
        return ST_OK;
    endfunction

    function automatic alloc_result_t heap_step(logic [1:0] md, logic [15:0] sz,
                                                logic [15:0] pa);
        alloc_result_t r;
        int unsigned   idx;
        int unsigned   old;
        int unsigned   ga;
        bit            hit;
        r.st   = ST_NOTFOUND;
        r.addr = '0;
        r.copy = '0;
        hit    = 1'b0;
        idx    = 0;
        if (md == MODE_ALLOC)
        begin
            r.st   = first_fit(sz, ga);
            r.addr = ga[15:0];
            return r;
        end
        if (md != MODE_FREE && md != MODE_REALLOC) return r;
        for (int unsigned i = 0; i < seg_cnt; i++)
            if (seg_off[i] == pa)
            begin
                hit = !seg_free[i];
                idx = i;
                break;
            end
        if (!hit) return r;
        old = seg_len[idx];
        release_merge(idx);
        if (md == MODE_FREE)
        begin
            r.st = ST_OK;
            return r;
        end
        r.st   = first_fit(sz, ga);
        r.addr = ga[15:0];
        if (r.st == ST_OK) r.copy = old[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender: drive one request word, hold until accepted. Valid drops
    // only for an idle burst or when the caller ends a stretch of traffic.
    // ------------------------------------------------------------------
    task automatic send_word(logic [1:0] md, logic [15:0] sz, logic [15:0] pa,
                             bit typed, alloc_result_t want);
        alloc_result_t p;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= md;
        request_size    <= sz;
        payload_address <= pa;
        do @(posedge clk); while (!in_ready);
        p = heap_step(md, sz, pa);
        if (typed && (p.st != want.st || p.addr != want.addr || p.copy != want.copy))
            report_mismatch("typed row vs predictor", p.st, want.st);
        pending_results.push_back(typed ? want : p);
        if (md == MODE_ALLOC && p.st == ST_OK) live_addrs.push_back(p.addr);
        if (md == MODE_REALLOC && p.st == ST_OK) live_addrs.push_back(p.addr);
    endtask

    // Pick an address: mostly a live payload, otherwise noise.
    function automatic logic [15:0] pick_addr();
        int j;
        if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8)
        begin
            j = $urandom_range(0, live_addrs.size() - 1);
            pick_addr = live_addrs[j];
            live_addrs.delete(j);
            return pick_addr;
        end
        return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64) * 32);
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            2:       return 16'd0;
            default: return 16'($urandom_range(1, 600));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        req_row_t      rows[$];
        alloc_result_t w;
        logic [1:0]    md;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_ALLOC;
        request_size    = '0;
        payload_address = '0;
        mismatches      = 0;
        hold_out        = 1'b0;
        no_idle         = 1'b0;
        stim_done       = 1'b0;
        table_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed expectation only where obvious from reset state.
        rows = '{
            '{MODE_FREE,    16'd0,     16'd32,    1, ST_NOTFOUND, 16'd0,  16'd0},
            '{MODE_REALLOC, 16'd8,     16'd32,    1, ST_NOTFOUND, 16'd0,  16'd0},
            '{2'd3,         16'hFFFF,  16'hFFFF,  1, ST_NOTFOUND, 16'd0,  16'd0},
            '{MODE_ALLOC,   16'hFFFF,  16'd0,     1, ST_NOFIT,    16'd0,  16'd0},
            '{MODE_ALLOC,   16'd0,     16'd0,     1, ST_OK,       16'd32, 16'd0},
            '{MODE_ALLOC,   16'd100,   16'd0,     0, 0, 0, 0},
            '{MODE_ALLOC,   16'd1,     16'hFFFF,  0, 0, 0, 0},
            '{MODE_FREE,    16'hFFFF,  16'd64,    0, 0, 0, 0},
            '{MODE_FREE,    16'd0,     16'd64,    0, 0, 0, 0},
            '{MODE_REALLOC, 16'd40,    16'd32,    0, 0, 0, 0},
            '{MODE_REALLOC, 16'd200,   16'd196,   0, 0, 0, 0},
            '{MODE_ALLOC,   16'd65400, 16'd0,     0, 0, 0, 0},
            '{MODE_ALLOC,   16'd65535, 16'd0,     0, 0, 0, 0},
            '{MODE_FREE,    16'd0,     16'hAAAA,  0, 0, 0, 0},
            '{MODE_FREE,    16'd0,     16'h5555,  0, 0, 0, 0},
            '{2'd3,         16'h0000,  16'h0000,  0, 0, 0, 0}
        };
        foreach (rows[i])
        begin
            w.st   = rows[i].st;
            w.addr = rows[i].addr;
            w.copy = rows[i].copy;
            send_word(rows[i].md, rows[i].sz, rows[i].pa, rows[i].typed, w);
        end

        // Fill the table to reach the table-full case, then drain.
        for (int i = 0; i < 70; i++)
            send_word(MODE_ALLOC, 16'($urandom_range(1, 64)), 16'd0, 0, w);
        in_valid <= 1'b0;

        // Sender pause until every expected word has come back.
        wait (pending_results.size() == 0);
        @(posedge clk);

        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == 300) hold_out = 1'b1;   // receiver takes a long break
            if (i == N_RAND - 200) no_idle = 1'b1;
            md = MODE_ALLOC;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: md = MODE_ALLOC;
                4, 5, 6:    md = MODE_FREE;
                7, 8:       md = MODE_REALLOC;
                default:    md = 2'($urandom_range(0, 3));
            endcase
            send_word(md, pick_size(), (md == MODE_ALLOC) ? 16'($urandom) : pick_addr(),
                      0, w);
        end
        in_valid  <= 1'b0;
        stim_done <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off, checks on acceptance.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);   // input must stall behind this
                hold_out = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", status, -1);
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st) report_mismatch("status", status, e.st);
                if (result_address !== e.addr)
                    report_mismatch("result_address", result_address, e.addr);
                if (copy_length !== e.copy)
                    report_mismatch("copy_length", copy_length, e.copy);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog and end of run
    // ------------------------------------------------------------------
    initial
    begin
        dog = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || hold_out)
                dog = 0;
            else
                dog++;
            if (dog >= DOG_MAX)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (pending_results.size() == 0);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
